// ----- sv/csa_pkg.sv -----
// Shared types, codes and default sizes of the contiguous slot allocator.
`default_nettype none

package csa_pkg;

  localparam int unsigned SlotCountDef  = 32;
  localparam int unsigned OwnerWidthDef = 8;

  localparam int unsigned NeedW  = 6;
  localparam int unsigned TagW   = 8;
  localparam int unsigned StartW = 5;

  localparam logic [1:0] FIT_BEST   = 2'd0;
  localparam logic [1:0] FIT_FIRST  = 2'd1;
  localparam logic [1:0] FIT_WORST  = 2'd2;
  localparam logic [1:0] FIT_REFUSE = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [NeedW-1:0]  slots_wanted;
    logic [TagW-1:0]   owner_tag;
  } csa_req_t;

  typedef struct packed {
    logic              status;
    logic [StartW-1:0] run_start;
  } csa_rsp_t;

endpackage

`default_nettype wire

// ----- sv/contiguous_slot_allocator_core.sv -----
// Top level of the contiguous slot allocator: owner memory, scan and commit sequencer.
//
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------------------------
//   request   | start / busy           | req_i  (opcode, slots_wanted, owner_tag)
//   response  | done_o (one-cycle)     | rsp_o  (status, run_start)
//   config    | cfg_we_i               | cfg_wdata_i (fit_strategy)
//
// A request runs from acceptance to the done strobe through a scan of every slot and,
// on a granted allocate that wants any slots, a commit that tags each granted slot.
// The single read port of the owner memory sets the pace: the scan reads one slot
// per cycle and the commit writes one slot per cycle. busy is high for all of it.
// Reset clears the sequencer and the per-slot valid bits, so every slot reads as free
// at once; no clearing pass is needed. The receiver cannot stall the response.
`default_nettype none

module contiguous_slot_allocator_core #(
  parameter int unsigned SLOT_COUNT  = csa_pkg::SlotCountDef,
  parameter int unsigned OWNER_WIDTH = csa_pkg::OwnerWidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire csa_pkg::csa_req_t req_i,
  output logic                  done_o,
  output csa_pkg::csa_rsp_t     rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_wdata_i
);
  import csa_pkg::*;

  // Index width, run-length width and a common width for comparing lengths.
  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned LW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CW = (LW > NeedW) ? LW : NeedW;
  localparam logic [IW-1:0] LastIdx = IW'(SLOT_COUNT - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  // Owner memory with one registered read port and one write port. Slots that were
  // never written since reset are marked by a cleared valid bit and read as free.
  logic [OWNER_WIDTH-1:0] mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  valid_q;
  logic [OWNER_WIDTH-1:0] rdata_q;
  logic                   rvalid_q;

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [OWNER_WIDTH-1:0] mem_wdata;
  logic                   mem_re;

  logic [1:0]             state_q, state_d;
  logic [1:0]             strategy_q;
  logic                   op_q;
  logic [NeedW-1:0]       need_q;
  logic [OWNER_WIDTH-1:0] owner_q;

  logic                   issue_q, issue_d;
  logic [IW-1:0]          rd_ptr_q, rd_ptr_d;
  logic                   pend_q, pend_d;
  logic [IW-1:0]          proc_idx_q, proc_idx_d;

  logic [LW-1:0]          cur_len_q, cur_len_d;
  logic [IW-1:0]          cur_start_q, cur_start_d;
  logic                   found_q, found_d;
  logic [IW-1:0]          chosen_start_q, chosen_start_d;
  logic [LW-1:0]          chosen_len_q, chosen_len_d;

  logic [IW-1:0]          wr_ptr_q, wr_ptr_d;
  logic [NeedW-1:0]       wr_left_q, wr_left_d;

  logic                   done_q, done_d;
  csa_rsp_t               rsp_q, rsp_d;

  logic [OWNER_WIDTH-1:0] slot_val;
  logic                   slot_free;
  logic                   is_last;
  logic [IW-1:0]          run_s;
  logic                   cand_vld;
  logic [IW-1:0]          cand_s;
  logic [LW-1:0]          cand_len;
  logic                   cand_fits;
  logic                   cand_take;
  logic                   fin_found;
  logic [IW-1:0]          fin_start;
  logic [OWNER_WIDTH-1:0] req_owner;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rvalid_q <= valid_q[rd_ptr_q];
      end
    end
  end

  // The owner tag keeps only its low OWNER_WIDTH bits, zero-extended when wider.
  assign req_owner = OWNER_WIDTH'({{OWNER_WIDTH{1'b0}}, req_i.owner_tag});

  // Decode of the slot whose read data returned this cycle.
  assign slot_val  = rvalid_q ? rdata_q : '0;
  assign slot_free = (slot_val == '0);
  assign is_last   = (proc_idx_q == LastIdx);
  assign run_s     = (cur_len_q == '0) ? proc_idx_q : cur_start_q;

  // A run closes at the first occupied slot after it or at the last slot.
  always_comb begin
    cand_vld = 1'b0;
    cand_s   = cur_start_q;
    cand_len = cur_len_q;
    if (pend_q && (op_q == OP_ALLOC)) begin
      if (slot_free && is_last) begin
        cand_vld = 1'b1;
        cand_s   = run_s;
        cand_len = LW'(cur_len_q + 1'b1);
      end else if (!slot_free && (cur_len_q != '0)) begin
        cand_vld = 1'b1;
      end
    end
  end

  assign cand_fits = cand_vld && (CW'(cand_len) >= CW'(need_q));

  always_comb begin
    unique case (strategy_q)
      FIT_BEST:  cand_take = cand_fits && (!found_q || (cand_len < chosen_len_q));
      FIT_FIRST: cand_take = cand_fits && !found_q;
      FIT_WORST: cand_take = cand_fits && (!found_q || (cand_len > chosen_len_q));
      default:   cand_take = 1'b0;
    endcase
  end

  assign fin_found = found_q || cand_take;
  assign fin_start = cand_take ? cand_s : chosen_start_q;

  always_comb begin
    state_d        = state_q;
    issue_d        = 1'b0;
    rd_ptr_d       = rd_ptr_q;
    pend_d         = 1'b0;
    proc_idx_d     = rd_ptr_q;
    cur_len_d      = cur_len_q;
    cur_start_d    = cur_start_q;
    found_d        = fin_found;
    chosen_start_d = fin_start;
    chosen_len_d   = cand_take ? cand_len : chosen_len_q;
    wr_ptr_d       = wr_ptr_q;
    wr_left_d      = wr_left_q;
    done_d         = 1'b0;
    rsp_d          = rsp_q;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = proc_idx_q;
    mem_wdata      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d      = S_SCAN;
          issue_d      = 1'b1;
          rd_ptr_d     = '0;
          cur_len_d    = '0;
          found_d      = 1'b0;
          chosen_len_d = '0;
        end
      end
      S_SCAN: begin
        // Read issue: one slot per cycle until the last one is requested.
        if (issue_q) begin
          mem_re   = 1'b1;
          pend_d   = 1'b1;
          issue_d  = (rd_ptr_q != LastIdx);
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        // Returned data: run tracking for allocate, match-and-clear for free.
        if (pend_q) begin
          if (slot_free) begin
            cur_start_d = run_s;
            cur_len_d   = LW'(cur_len_q + 1'b1);
          end else begin
            cur_len_d = '0;
          end
          if ((op_q == OP_FREE) && (slot_val == owner_q)) begin
            mem_we = 1'b1;
          end
          if (is_last) begin
            if (op_q == OP_FREE) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
              rsp_d   = '{status: STATUS_OK, run_start: '0};
            end else if (!fin_found) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
              rsp_d   = '{status: STATUS_NOSPACE, run_start: '0};
            end else begin
              rsp_d = '{status: STATUS_OK, run_start: StartW'(fin_start)};
              if (need_q == '0) begin
                state_d = S_IDLE;
                done_d  = 1'b1;
              end else begin
                state_d   = S_WRITE;
                wr_ptr_d  = fin_start;
                wr_left_d = need_q;
              end
            end
          end
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        mem_wdata = owner_q;
        wr_ptr_d  = wr_ptr_q + 1'b1;
        wr_left_d = wr_left_q - 1'b1;
        if (wr_left_q == NeedW'(1)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      strategy_q <= FIT_BEST;
      issue_q    <= 1'b0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        strategy_q <= cfg_wdata_i;
      end
    end
  end

  // Payload and datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start) begin
      op_q    <= req_i.opcode;
      need_q  <= req_i.slots_wanted;
      owner_q <= req_owner;
    end
    rd_ptr_q       <= rd_ptr_d;
    proc_idx_q     <= proc_idx_d;
    cur_len_q      <= cur_len_d;
    cur_start_q    <= cur_start_d;
    chosen_start_q <= chosen_start_d;
    chosen_len_q   <= chosen_len_d;
    wr_ptr_q       <= wr_ptr_d;
    wr_left_q      <= wr_left_d;
    rsp_q          <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A response only follows a cycle in which a request was in progress.
  a_done_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != S_IDLE))
    else $error("response strobe without a request in progress");

  // The memory is only written while scanning a free request or committing a grant.
  a_write_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_WRITE) || ((state_q == S_SCAN) && (op_q == OP_FREE))))
    else $error("owner memory written outside a scan or commit");

  // The commit phase always has at least one slot left to tag.
  a_write_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (wr_left_q != '0))
    else $error("commit phase entered with nothing to write");

  // A new request only begins from a start pulse seen while idle.
  a_busy_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

`default_nettype wire

// ----- test/contiguous_slot_allocator_core_tb.sv -----
// Self-checking testbench of the contiguous slot allocator core: directed table, then random requests.
`default_nettype none

module contiguous_slot_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csa_pkg::*;

  // The block is built at its default size, so the slot map below mirrors it.
  localparam int unsigned Slots       = SlotCountDef;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseItems  = 75;
  localparam int unsigned TailCycles  = 80;
  localparam int unsigned NumDirected = 25;

  // One row of the directed table. When grant_typed is set, the expected
  // response is the one typed into the row; otherwise the slot map
  // predictor supplies it. An optional strategy write comes first.
  typedef struct packed {
    logic             wr_strategy;
    logic [1:0]       strategy;
    logic             opcode;
    logic [NeedW-1:0] need;
    logic [TagW-1:0]  tag;
    logic             grant_typed;
    logic             status;
    logic [StartW-1:0] run_start;
  } stim_row_t;

  localparam stim_row_t DirectedRows [NumDirected] = '{
    // Fill the whole map with one owner, then nothing else fits.
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd32, 8'd1,   1'b1, STATUS_OK,      5'd0},
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd1,  8'd2,   1'b1, STATUS_NOSPACE, 5'd0},
    // Zero slots wanted with no free slot at all is refused.
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd0,  8'd3,   1'b1, STATUS_NOSPACE, 5'd0},
    '{1'b0, FIT_BEST,   OP_FREE,  6'd0,  8'd1,   1'b1, STATUS_OK,      5'd0},
    // Requests beyond the number of slots are refused.
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd33, 8'd5,   1'b1, STATUS_NOSPACE, 5'd0},
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd63, 8'd255, 1'b1, STATUS_NOSPACE, 5'd0},
    // Zero slots wanted on an empty map reports slot 0 and tags nothing.
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd0,  8'd7,   1'b1, STATUS_OK,      5'd0},
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd4,  8'd10,  1'b1, STATUS_OK,      5'd0},
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd3,  8'd11,  1'b0, STATUS_OK,      5'd0},
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd2,  8'd12,  1'b0, STATUS_OK,      5'd0},
    // A free ignores the slot count field.
    '{1'b0, FIT_BEST,   OP_FREE,  6'd42, 8'd11,  1'b1, STATUS_OK,      5'd0},
    // Best fit now prefers the small hole left by the free.
    '{1'b0, FIT_BEST,   OP_ALLOC, 6'd2,  8'd13,  1'b0, STATUS_OK,      5'd0},
    '{1'b1, FIT_FIRST,  OP_ALLOC, 6'd1,  8'd14,  1'b0, STATUS_OK,      5'd0},
    '{1'b1, FIT_WORST,  OP_ALLOC, 6'd5,  8'd255, 1'b0, STATUS_OK,      5'd0},
    '{1'b0, FIT_WORST,  OP_ALLOC, 6'd0,  8'd0,   1'b0, STATUS_OK,      5'd0},
    // An allocate with owner zero writes zeros, so the slots stay free.
    '{1'b0, FIT_WORST,  OP_ALLOC, 6'd3,  8'd0,   1'b0, STATUS_OK,      5'd0},
    '{1'b0, FIT_WORST,  OP_FREE,  6'd0,  8'd0,   1'b1, STATUS_OK,      5'd0},
    // The refusing strategy turns down every allocate but still frees.
    '{1'b1, FIT_REFUSE, OP_ALLOC, 6'd1,  8'd20,  1'b1, STATUS_NOSPACE, 5'd0},
    '{1'b0, FIT_REFUSE, OP_FREE,  6'd0,  8'd10,  1'b1, STATUS_OK,      5'd0},
    '{1'b0, FIT_REFUSE, OP_ALLOC, 6'd0,  8'd1,   1'b1, STATUS_NOSPACE, 5'd0},
    '{1'b1, FIT_BEST,   OP_ALLOC, 6'd32, 8'd128, 1'b0, STATUS_OK,      5'd0},
    '{1'b0, FIT_BEST,   OP_FREE,  6'd0,  8'd255, 1'b1, STATUS_OK,      5'd0},
    '{1'b0, FIT_BEST,   OP_FREE,  6'd0,  8'd12,  1'b1, STATUS_OK,      5'd0},
    '{1'b0, FIT_BEST,   OP_FREE,  6'd63, 8'd13,  1'b1, STATUS_OK,      5'd0},
    '{1'b0, FIT_BEST,   OP_FREE,  6'd0,  8'd14,  1'b1, STATUS_OK,      5'd0}
  };

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  csa_req_t   request_bus;
  logic       done;
  csa_rsp_t   grant;
  logic       strategy_we;
  logic [1:0] strategy_wdata;

  // Predictor state: the owner of every slot and the active strategy.
  bit [TagW-1:0] owner_of_slot [Slots];
  logic [1:0]    fit_mode;

  // Responses still owed by the block, oldest first.
  csa_rsp_t expected_grants [$];
  int unsigned mismatch_count;

  contiguous_slot_allocator_core #(
    .SLOT_COUNT (SlotCountDef),
    .OWNER_WIDTH(OwnerWidthDef)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (request_bus),
    .done_o     (done),
    .rsp_o      (grant),
    .cfg_we_i   (strategy_we),
    .cfg_wdata_i(strategy_wdata)
  );

  always #5 clk = ~clk;

  // Applies one request to the predicted slot map and returns the response
  // the block owes for it. Runs are scanned from slot 0 upward; each maximal
  // free run that is long enough is a candidate, and the strategy decides
  // which candidate wins, with ties going to the earliest run.
  function automatic csa_rsp_t predict_grant(csa_req_t req);
    int unsigned   idx;
    int unsigned   run_first;
    int unsigned   run_len;
    int unsigned   pick_first;
    int unsigned   pick_len;
    int unsigned   need;
    bit            found;
    bit            take;
    csa_rsp_t      rsp;
    rsp   = '0;
    need  = req.slots_wanted;
    found = 1'b0;
    pick_first = 0;
    pick_len   = 0;
    if (req.opcode == OP_FREE) begin
      // Owner zero matches the free slots, which changes nothing.
      for (idx = 0; idx < Slots; idx++) begin
        if (owner_of_slot[idx] == req.owner_tag) owner_of_slot[idx] = '0;
      end
    end else begin
      idx = 0;
      while (idx < Slots) begin
        if (owner_of_slot[idx] != '0) begin
          idx++;
        end else begin
          run_first = idx;
          run_len   = 0;
          while (idx < Slots && owner_of_slot[idx] == '0) begin
            run_len++;
            idx++;
          end
          take = 1'b0;
          if (run_len >= need) begin
            case (fit_mode)
              FIT_FIRST: take = !found;
              FIT_BEST:  take = !found || run_len < pick_len;
              FIT_WORST: take = !found || run_len > pick_len;
              default:   take = 1'b0;
            endcase
          end
          if (take) begin
            found      = 1'b1;
            pick_first = run_first;
            pick_len   = run_len;
          end
        end
      end
      if (found) begin
        for (idx = 0; idx < need && pick_first + idx < Slots; idx++) begin
          owner_of_slot[pick_first + idx] = req.owner_tag;
        end
        rsp.run_start = pick_first[StartW-1:0];
      end else begin
        rsp.status = STATUS_NOSPACE;
      end
    end
    return rsp;
  endfunction

  // Offers one request after an idle gap and holds it until the block takes
  // it. Called and returning at a falling edge. start stays high on return,
  // so back-to-back requests never lower and raise it within one step.
  task automatic send_request(input csa_req_t req, input int unsigned gap,
                              input bit typed, input csa_rsp_t typed_rsp);
    csa_rsp_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    request_bus <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The request was taken at this edge; the predictor sees it now, in
    // acceptance order.
    predicted = predict_grant(req);
    expected_grants.push_back(typed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  // Stops offering requests and waits until the block has answered all of
  // them and is idle. Every request yields a response, so an empty queue
  // with busy low means nothing is in flight.
  task automatic drain_requests();
    start <= 1'b0;
    @(negedge clk);
    while (expected_grants.size() != 0 || busy) @(negedge clk);
  endtask

  // Writes the strategy register; only called while the block is idle.
  task automatic write_strategy(input logic [1:0] mode);
    strategy_we    <= 1'b1;
    strategy_wdata <= mode;
    @(negedge clk);
    strategy_we <= 1'b0;
    fit_mode    = mode;
  endtask

  // Response checker. done is sampled at the rising edge that ends its
  // one-cycle strobe; every response must match the oldest expectation.
  always @(posedge clk) begin
    csa_rsp_t want;
    if (rst_n && done) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: response with none expected: expected nothing, actual status %0d run_start %0d",
                 $time, grant.status, grant.run_start);
        mismatch_count++;
      end else begin
        want = expected_grants.pop_front();
        if (grant.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, grant.status);
          mismatch_count++;
        end
        if (grant.run_start !== want.run_start) begin
          $display("%0t: run_start mismatch: expected %0d, actual %0d",
                   $time, want.run_start, grant.run_start);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases, each with a
  // strategy written while the block is idle.
  initial begin
    csa_req_t    req;
    csa_rsp_t    typed_rsp;
    stim_row_t   row;
    int unsigned phase;
    int unsigned item;
    int unsigned gap;
    int unsigned pick;
    bit          no_gaps;
    logic [1:0]  mode;

    clk            = 1'b0;
    rst_n          = 1'b0;
    start          <= 1'b0;
    request_bus    <= '0;
    strategy_we    <= 1'b0;
    strategy_wdata <= '0;
    mismatch_count = 0;
    fit_mode       = FIT_BEST;
    for (int unsigned s = 0; s < Slots; s++) owner_of_slot[s] = '0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: extremes, every strategy and the special cases.
    for (int unsigned r = 0; r < NumDirected; r++) begin
      row = DirectedRows[r];
      if (row.wr_strategy) begin
        drain_requests();
        write_strategy(row.strategy);
      end
      req.opcode       = row.opcode;
      req.slots_wanted = row.need;
      req.owner_tag    = row.tag;
      typed_rsp.status    = row.status;
      typed_rsp.run_start = row.run_start;
      send_request(req, $urandom_range(0, 13), row.grant_typed, typed_rsp);
    end

    // Random phases. The first four walk every strategy; later ones pick
    // at random. Every third phase runs with no idle gaps, apart from the occasional drain.
    for (phase = 0; phase < RandPhases; phase++) begin
      drain_requests();
      mode = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
      write_strategy(mode);
      no_gaps = (phase % 3 == 2);
      for (item = 0; item < PhaseItems; item++) begin
        // Owners come mostly from a small pool so that frees hit live runs.
        pick = $urandom_range(0, 99);
        req.owner_tag = (pick < 80) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 28) begin
          req.opcode       = OP_FREE;
          req.slots_wanted = 6'($urandom_range(0, 63));
        end else begin
          req.opcode = OP_ALLOC;
          pick = $urandom_range(0, 99);
          if (pick < 60) req.slots_wanted = 6'($urandom_range(1, 6));
          else if (pick < 85) req.slots_wanted = 6'($urandom_range(7, 16));
          else if (pick < 95) req.slots_wanted = 6'($urandom_range(17, 32));
          else req.slots_wanted = 6'($urandom_range(0, 63));
        end
        gap = (no_gaps || $urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 13);
        // Now and then the sender holds off until every response is back.
        if ($urandom_range(0, 39) == 0) drain_requests();
        send_request(req, gap, 1'b0, '0);
      end
    end

    drain_requests();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
